[rtl/set_assoc_cache_tag_lookup_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag lookup
// Shared property shapes, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH

// same-cycle implication
`define SACL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache tag lookup: same-cycle check failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache tag lookup: next-cycle check failed");

`endif

[rtl/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Types and fixed constants of the set-associative cache tag lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

	// address layout
	localparam int ADDR_W   = 32;
	localparam int OFFSET_W = 2;

	// access clock
	localparam int          STAMP_W    = 32;
	localparam logic [31:0] CLOCK_INIT = 32'd0;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_MODE       = 1'd1;

	// replacement mode codes
	localparam logic REPL_STAMP = 1'b0;
	localparam logic REPL_ROUND = 1'b1;

	// write mode codes (code 3 behaves as write-back)
	localparam logic [1:0] WM_BACK     = 2'd0;
	localparam logic [1:0] WM_THROUGH  = 2'd1;
	localparam logic [1:0] WM_ALLOCATE = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// sequencer to scan unit
	typedef struct packed {
		logic start;	// first way of the set this cycle
		logic step;	// read data of one way is present
	} scan_ctl_t;

	// scan unit to sequencer
	typedef struct packed {
		logic stop;		// current way is invalid or matches
		logic found;		// last step stopped on a way
		logic hit;		// last step stopped on a match
		logic found_dirty;	// dirty bit of the way stopped on
		logic vic_dirty;	// dirty bit of the oldest-stamp way
		logic rr_dirty;		// dirty bit of the way under the pointer
	} scan_sts_t;

endpackage

[rtl/sacl_scan_unit.sv]
// ----------------------------------------------------------------------------
// sacl_scan_unit
// Shared tag and stamp comparator, stepped over the ways of one set.
// ----------------------------------------------------------------------------
module sacl_scan_unit
	import sacl_pkg::*;
#(
	parameter int WAY_W = 2,
	parameter int TAG_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [WAY_W-1:0] way,
	input  logic             line_valid,
	input  logic             line_dirty,
	input  logic [TAG_W-1:0] line_tag,
	input  logic [TAG_W-1:0] req_tag,
	input  logic [STAMP_W-1:0] stamp,
	input  logic [WAY_W-1:0] rr_ptr,
	output scan_sts_t        sts,
	output logic [WAY_W-1:0] found_way,
	output logic [WAY_W-1:0] vic_way
);

	logic               match_c;
	logic               stop_c;
	logic               older_c;
	logic               found_q;
	logic               hit_q;
	logic               found_dirty_q;
	logic               vic_dirty_q;
	logic               rr_dirty_q;
	logic [WAY_W-1:0]   found_way_q;
	logic [WAY_W-1:0]   vic_way_q;
	logic [STAMP_W-1:0] min_stamp_q;

	// compare of the current way
	assign match_c = line_valid && (line_tag == req_tag);
	assign stop_c  = !line_valid || match_c;
	// strict compare keeps the lowest way on equal stamps
	assign older_c = ctl.start || (stamp < min_stamp_q);

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
		end else if (ctl.step) begin
			found_q <= stop_c;
			hit_q   <= match_c;
		end
	end

	// running victim and per-way captures
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			found_way_q   <= way;
			found_dirty_q <= line_dirty;
			if (older_c) begin
				min_stamp_q <= stamp;
				vic_way_q   <= way;
				vic_dirty_q <= line_dirty;
			end
			if (way == rr_ptr) begin
				rr_dirty_q <= line_dirty;
			end
		end
	end

	assign sts.stop        = stop_c;
	assign sts.found       = found_q;
	assign sts.hit         = hit_q;
	assign sts.found_dirty = found_dirty_q;
	assign sts.vic_dirty   = vic_dirty_q;
	assign sts.rr_dirty    = rr_dirty_q;
	assign found_way       = found_way_q;
	assign vic_way         = vic_way_q;

endmodule

[rtl/set_assoc_cache_tag_lookup.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag lookup of a set-associative cache with stamp or round-robin victims.
//
//   channel   signals                                  direction
//   in        in_valid, in_ready, address              request in
//   out       out_valid, out_ready, hit, way_used,     result out
//             replaced, mem_reads, mem_writes
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write in
//
// A request reads 1 to WAYS ways of its set, from way 0 up, until a way is
// invalid or matches or the last way is read: the single tag/stamp
// comparator looks at one way per cycle through the registered memory port.
// After reset a clearing pass over all 2^(IDX_BITS+WAY_W) line addresses (256
// at the defaults) empties the line and pointer memories; in_ready is low meanwhile.
// The update cycle waits while a previous result is still held at the output.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_lookup_macros.svh"

module set_assoc_cache_tag_lookup
	import sacl_pkg::*;
#(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ADDR_W-1:0]      address,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [1:0]             way_used,
	output logic                   replaced,
	output logic                   mem_reads,
	output logic [1:0]             mem_writes,
	// configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_BITS = $clog2(SETS + 1) - 1;
	localparam int TAG_W    = ADDR_W - OFFSET_W - IDX_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MEM_AW   = IDX_BITS + WAY_W;
	localparam int LINE_W   = TAG_W + 2;
	localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

	state_t state_q, state_d;

	// configuration registers
	logic       repl_mode_q;
	logic [1:0] write_mode_q;

	// request registers
	logic [IDX_BITS-1:0] set_q;
	logic [TAG_W-1:0]    tag_q;
	logic [WAY_W-1:0]    way_q;
	logic [STAMP_W-1:0]  clock_q;
	logic [MEM_AW-1:0]   clr_q;

	// memories
	logic [LINE_W-1:0]  line_mem  [2**MEM_AW];
	logic [STAMP_W-1:0] stamp_mem [2**MEM_AW];
	logic [WAY_W-1:0]   ptr_mem   [2**IDX_BITS];
	logic [LINE_W-1:0]  line_rd_q;
	logic [STAMP_W-1:0] stamp_rd_q;
	logic [WAY_W-1:0]   ptr_rd_q;

	// control
	logic              rd_en;
	logic [MEM_AW-1:0] rd_addr;
	logic              commit;
	scan_ctl_t         scan_ctl;
	scan_sts_t         scan_sts;
	logic [WAY_W-1:0]  found_way;
	logic [WAY_W-1:0]  vic_way;

	// update datapath
	logic              use_stamp;
	logic              is_fill;
	logic              is_repl;
	logic              wt_mode;
	logic              wa_mode;
	logic [WAY_W-1:0]  way_sel;
	logic              victim_dirty;
	logic              new_dirty;
	logic              rd_c;
	logic [1:0]        wr_c;
	logic [WAY_W-1:0]  ptr_next;
	logic [STAMP_W-1:0] clock_next;
	logic [WAY_W+1:0]  way_ext;

	logic              line_we;
	logic [MEM_AW-1:0] line_waddr;
	logic [LINE_W-1:0] line_wdata;
	logic              stamp_we;
	logic              ptr_we;
	logic [IDX_BITS-1:0] ptr_waddr;
	logic [WAY_W-1:0]  ptr_wdata;

	// result registers
	logic       out_valid_q;
	logic       hit_q;
	logic [1:0] way_used_q;
	logic       replaced_q;
	logic       mem_reads_q;
	logic [1:0] mem_writes_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_mode_q  <= REPL_STAMP;
			write_mode_q <= WM_BACK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REPLACEMENT_MODE: repl_mode_q  <= cfg_data[0];
				CFG_WRITE_MODE:       write_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = {address[OFFSET_W +: IDX_BITS], {WAY_W{1'b0}}};
		scan_ctl.start = 1'b0;
		scan_ctl.step  = 1'b0;
		commit         = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == {MEM_AW{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rd_en   = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_ctl.step  = 1'b1;
				scan_ctl.start = (way_q == '0);
				if (scan_sts.stop || way_q == LAST_WAY) begin
					state_d = ST_UPDATE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = {set_q, way_q + WAY_W'(1)};
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// request capture and way counter
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			set_q <= address[OFFSET_W +: IDX_BITS];
			tag_q <= address[ADDR_W-1 -: TAG_W];
			way_q <= '0;
		end else if (state_q == ST_SCAN && rd_en) begin
			way_q <= way_q + WAY_W'(1);
		end
	end

	// clearing pass counter and access clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			clock_q <= CLOCK_INIT;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MEM_AW'(1);
			end
			if (commit && use_stamp) begin
				clock_q <= clock_next;
			end
		end
	end

	// shared comparator
	sacl_scan_unit #(
		.WAY_W (WAY_W),
		.TAG_W (TAG_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.way        (way_q),
		.line_valid (line_rd_q[LINE_W-1]),
		.line_dirty (line_rd_q[LINE_W-2]),
		.line_tag   (line_rd_q[TAG_W-1:0]),
		.req_tag    (tag_q),
		.stamp      (stamp_rd_q),
		.rr_ptr     (ptr_rd_q),
		.sts        (scan_sts),
		.found_way  (found_way),
		.vic_way    (vic_way)
	);

	// outcome of the search and traffic counts
	always_comb begin
		use_stamp    = (repl_mode_q == REPL_STAMP);
		wt_mode      = (write_mode_q == WM_THROUGH);
		wa_mode      = (write_mode_q == WM_ALLOCATE);
		is_fill      = scan_sts.found && !scan_sts.hit;
		is_repl      = !scan_sts.found;
		victim_dirty = use_stamp ? scan_sts.vic_dirty : scan_sts.rr_dirty;
		clock_next   = clock_q + STAMP_W'(1);
		ptr_next     = (ptr_rd_q == LAST_WAY) ? '0 : ptr_rd_q + WAY_W'(1);

		if (scan_sts.found) begin
			way_sel = found_way;
		end else if (use_stamp) begin
			way_sel = vic_way;
		end else begin
			way_sel = ptr_rd_q;
		end

		if (is_fill) begin
			rd_c      = 1'b0;
			wr_c      = {1'b0, wa_mode};
			new_dirty = 1'b0;
		end else if (is_repl) begin
			rd_c      = 1'b1;
			wr_c      = {1'b0, victim_dirty} + {1'b0, wt_mode || wa_mode};
			new_dirty = !wt_mode;
		end else begin
			rd_c      = 1'b1;
			wr_c      = {1'b0, wt_mode};
			new_dirty = wt_mode ? scan_sts.found_dirty : 1'b1;
		end

		way_ext = {2'b00, way_sel};
	end

	// memory write ports
	always_comb begin
		if (state_q == ST_CLEAR) begin
			line_we    = 1'b1;
			line_waddr = clr_q;
			line_wdata = '0;
			ptr_we     = 1'b1;
			ptr_waddr  = clr_q[MEM_AW-1 -: IDX_BITS];
			ptr_wdata  = '0;
		end else begin
			line_we    = commit;
			line_waddr = {set_q, way_sel};
			line_wdata = {1'b1, new_dirty, tag_q};
			ptr_we     = commit && !use_stamp && !is_fill;
			ptr_waddr  = set_q;
			ptr_wdata  = ptr_next;
		end
		stamp_we = commit && use_stamp;
	end

	// line memory: valid, dirty and tag per way
	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_waddr] <= line_wdata;
		end
		if (rd_en) begin
			line_rd_q <= line_mem[rd_addr];
		end
	end

	// access stamp memory
	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[{set_q, way_sel}] <= clock_next;
		end
		if (rd_en) begin
			stamp_rd_q <= stamp_mem[rd_addr];
		end
	end

	// round-robin pointer memory, read once per request
	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_waddr] <= ptr_wdata;
		end
		if (in_valid && in_ready) begin
			ptr_rd_q <= ptr_mem[address[OFFSET_W +: IDX_BITS]];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q        <= scan_sts.hit && scan_sts.found;
			way_used_q   <= way_ext[1:0];
			replaced_q   <= is_repl;
			mem_reads_q  <= rd_c;
			mem_writes_q <= wr_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign way_used   = way_used_q;
	assign replaced   = replaced_q;
	assign mem_reads  = mem_reads_q;
	assign mem_writes = mem_writes_q;

	// checks
	`SACL_ASSERT_NOW(a_wr_range, clk, arst_n, out_valid, mem_writes != 2'd3)
	`SACL_ASSERT_NOW(a_hit_reads, clk, arst_n, out_valid && hit, mem_reads && !replaced)
	`SACL_ASSERT_NOW(a_fill_quiet, clk, arst_n, out_valid && !mem_reads, !hit && !replaced)
	`SACL_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

[tb/sv/cache_lookup_checker.sv]
// ----------------------------------------------------------------------------
// cache_lookup_checker
// Watches the request, result and register channels of the tag lookup. It
// keeps its own copy of the line state and computes the expected hit, way and
// memory traffic of every accepted request. It compares each accepted result
// in order and counts mismatches for the top level.
// ----------------------------------------------------------------------------
module cache_lookup_checker
	import sacl_pkg::*;
#(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [ADDR_W-1:0]      address,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic                   hit,
	input  logic [1:0]             way_used,
	input  logic                   replaced,
	input  logic                   mem_reads,
	input  logic [1:0]             mem_writes,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	// floor(log2(SETS)) index bits
	localparam int SET_W = $clog2(SETS + 1) - 1;
	localparam int TAG_W = ADDR_W - OFFSET_W - SET_W;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef struct packed {
		logic       hit;
		logic [1:0] way;
		logic       replaced;
		logic       rd;
		logic [1:0] wr;
	} lookup_t;

	// shadow line state
	logic [TAG_W-1:0]    line_tag   [SETS][WAYS];
	bit                  line_valid [SETS][WAYS];
	bit                  line_dirty [SETS][WAYS];
	logic [STAMP_W-1:0]  line_stamp [SETS][WAYS];
	logic [STAMP_W-1:0]  stamp_clock;
	logic [WAY_W-1:0]    rr_ptr     [SETS];
	logic                repl_mode;
	logic [1:0]          wr_mode;

	lookup_t lookups_due[$];

	// one access: search, then fill, hit or evict; updates the shadow state
	function automatic lookup_t predict_access(input logic [ADDR_W-1:0] addr);
		logic [SET_W-1:0] s;
		logic [TAG_W-1:0] t;
		int               found;
		int               victim;
		int               w;
		bit               by_stamp;
		lookup_t          r;
		s        = addr[OFFSET_W +: SET_W];
		t        = addr[ADDR_W-1 -: TAG_W];
		by_stamp = (repl_mode == REPL_STAMP);
		r        = '0;
		found    = WAYS;
		if (by_stamp)
			stamp_clock = stamp_clock + STAMP_W'(1);

		// first invalid or matching way, from way 0 up
		for (w = 0; w < WAYS; w++) begin
			if (found == WAYS) begin
				if (!line_valid[s][w]) begin
					found = w;
				end else if (line_tag[s][w] == t) begin
					found = w;
					r.hit = 1'b1;
				end
			end
		end

		if (r.hit) begin
			r.way = 2'(found);
			r.rd  = 1'b1;
			if (by_stamp)
				line_stamp[s][found] = stamp_clock;
			else
				rr_ptr[s] = WAY_W'((int'(rr_ptr[s]) + 1) % WAYS);
			if (wr_mode == WM_THROUGH)
				r.wr = 2'd1;
			else
				line_dirty[s][found] = 1'b1;
		end else if (found < WAYS) begin
			// fill an empty way
			line_tag[s][found]   = t;
			line_valid[s][found] = 1'b1;
			if (by_stamp)
				line_stamp[s][found] = stamp_clock;
			r.way = 2'(found);
			if (wr_mode == WM_ALLOCATE)
				r.wr = 2'd1;
		end else begin
			// evict: oldest stamp (lowest way on ties) or the set's pointer
			victim = 0;
			if (by_stamp) begin
				for (w = 1; w < WAYS; w++)
					if (line_stamp[s][w] < line_stamp[s][victim])
						victim = w;
				line_stamp[s][victim] = stamp_clock;
			end else begin
				victim    = int'(rr_ptr[s]) % WAYS;
				rr_ptr[s] = WAY_W'((victim + 1) % WAYS);
			end
			line_tag[s][victim] = t;
			r.replaced = 1'b1;
			r.way      = 2'(victim);
			r.rd       = 1'b1;
			if (line_dirty[s][victim]) begin
				r.wr = r.wr + 2'd1;
				line_dirty[s][victim] = 1'b0;
			end
			if (wr_mode == WM_THROUGH)
				r.wr = r.wr + 2'd1;
			else
				line_dirty[s][victim] = 1'b1;
			if (wr_mode == WM_ALLOCATE)
				r.wr = r.wr + 2'd1;
		end
		return r;
	endfunction

	function automatic int field_error(input string field, input logic [1:0] want,
			input logic [1:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		return 1;
	endfunction

	// compare results, then predict new requests; all on pre-edge values
	always @(posedge clk or negedge arst_n) begin
		lookup_t oldest;
		int      s;
		int      w;
		if (!arst_n) begin
			for (s = 0; s < SETS; s++) begin
				rr_ptr[s] = '0;
				for (w = 0; w < WAYS; w++) begin
					line_tag[s][w]   = '0;
					line_valid[s][w] = 1'b0;
					line_dirty[s][w] = 1'b0;
					line_stamp[s][w] = '0;
				end
			end
			stamp_clock = CLOCK_INIT;
			repl_mode   = REPL_STAMP;
			wr_mode     = WM_BACK;
			lookups_due.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_REPLACEMENT_MODE: repl_mode = cfg_data[0];
					CFG_WRITE_MODE:       wr_mode   = cfg_data;
					default: ;
				endcase
			end

			// result check
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					$display("%0t: result with none pending: hit %0d way %0d repl %0d rd %0d wr %0d",
						$time, hit, way_used, replaced, mem_reads, mem_writes);
					mismatches <= mismatches + 1;
				end else begin
					oldest = lookups_due.pop_front();
					mismatches <= mismatches
						+ field_error("hit", oldest.hit, hit)
						+ field_error("way_used", oldest.way, way_used)
						+ field_error("replaced", oldest.replaced, replaced)
						+ field_error("mem_reads", oldest.rd, mem_reads)
						+ field_error("mem_writes", oldest.wr, mem_writes);
				end
			end

			if (in_valid && in_ready)
				lookups_due.push_back(predict_access(address));

			outstanding <= lookups_due.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Request stimulus and verdict for the cache tag lookup. A directed burst
// covers address extremes, fills, hits and evictions; then random accesses
// focused on a few sets and tags run under each register setting, mostly with
// random sender and receiver stalls. Checking is in the checker module.
// ----------------------------------------------------------------------------
module tb_top
	import sacl_pkg::*;
();

	localparam int SETS        = 64;
	localparam int WAYS        = 4;
	localparam int SET_W       = $clog2(SETS + 1) - 1;
	localparam int TAG_W       = ADDR_W - OFFSET_W - SET_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int TAIL_CYCLES = 10;

	// undefined write mode code, counted as write-back
	localparam logic [1:0] WM_UNDEFINED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [ADDR_W-1:0]      address = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   hit;
	logic [1:0]             way_used;
	logic                   replaced;
	logic                   mem_reads;
	logic [1:0]             mem_writes;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int mismatches;
	int outstanding;
	int send_idle_pct = 7;
	int recv_idle_pct = 66;
	int cycles = 0;

	// stamp mode is not selected again once round-robin has filled lines,
	// since those lines carry no stamp
	logic       phase_repl [PHASES] = '{REPL_STAMP, REPL_STAMP, REPL_STAMP, REPL_STAMP,
		REPL_ROUND, REPL_ROUND, REPL_ROUND, REPL_ROUND};
	logic [1:0] phase_wm   [PHASES] = '{WM_BACK, WM_THROUGH, WM_ALLOCATE, WM_UNDEFINED,
		WM_UNDEFINED, WM_ALLOCATE, WM_THROUGH, WM_BACK};

	// extremes, byte offset ignored, set 0 filled then evicted repeatedly
	logic [ADDR_W-1:0] corner_addrs [19] = '{
		32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFC,
		32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 32'h0000_0400, 32'h0000_0101,
		32'h0000_0500, 32'h0000_0402, 32'h0000_0600, 32'h8000_0000, 32'h7FFF_FFFF,
		32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0700};

	set_assoc_cache_tag_lookup #(
		.SETS(SETS),
		.WAYS(WAYS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.address   (address),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.way_used  (way_used),
		.replaced  (replaced),
		.mem_reads (mem_reads),
		.mem_writes(mem_writes),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cache_lookup_checker #(
		.SETS(SETS),
		.WAYS(WAYS)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.address    (address),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.way_used   (way_used),
		.replaced   (replaced),
		.mem_reads  (mem_reads),
		.mem_writes (mem_writes),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// mostly a few sets and tags so that hits and evictions are frequent
	function automatic logic [ADDR_W-1:0] random_address();
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag_val;
		if ($urandom_range(99) < 10)
			return $urandom();
		set_idx = ($urandom_range(99) < 75) ? SET_W'($urandom_range(3)) : SET_W'($urandom());
		tag_val = ($urandom_range(99) < 80) ? TAG_W'($urandom_range(6)) : TAG_W'($urandom());
		return {tag_val, set_idx, OFFSET_W'($urandom())};
	endfunction

	// called just after a rising edge; leaves valid high after the accept
	task automatic send_request(input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		address  <= addr;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// both registers; unused upper data bit of the replacement mode write is random
	task automatic set_config(input logic repl, input logic [1:0] wm);
		logic [CFG_INDEX_W-1:0] idx [2];
		logic [CFG_DATA_W-1:0]  val [2];
		int                     i;
		idx = '{CFG_REPLACEMENT_MODE, CFG_WRITE_MODE};
		val = '{{1'($urandom()), repl}, wm};
		for (i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(negedge clk);
			while (!cfg_ready)
				@(negedge clk);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		int p;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(REPL_STAMP, WM_BACK);
		foreach (corner_addrs[i])
			send_request(corner_addrs[i]);
		in_valid <= 1'b0;

		for (p = 0; p < PHASES; p++) begin
			// sender rare and receiver heavy stalls, then swapped, then none
			if (p < 3) begin
				send_idle_pct = 7;
				recv_idle_pct = 66;
			end else if (p < 6) begin
				send_idle_pct = 66;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_drained();
			set_config(phase_repl[p], phase_wm[p]);
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(random_address());
			in_valid <= 1'b0;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[set_assoc_cache_tag_lookup.f]
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_scan_unit.sv
rtl/set_assoc_cache_tag_lookup.sv
tb/sv/cache_lookup_checker.sv
tb/sv/tb_top.sv
